// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the rotation matrix to quaternion unit.
// No dependencies; used by rotation_matrix_to_quaternion_unit.
package rmq_pkg;

	// Default number of fraction bits in the fixed-point format.
	localparam int unsigned FRAC_BITS_DEF = 14;
	// Width of every matrix element and quaternion component.
	localparam int unsigned DATA_W = 16;
	// Quotient bits resolved by the divider; one more than the output width.
	localparam int unsigned QUOT_W = 17;

	// Component that takes the halved square root; the others are divided.
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

endpackage

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, fully pipelined (Shepperd's method).
// Depends on rmq_pkg for the branch select type and width constants.
//
// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall   m00 .. m22, 16-bit signed
// out      from block out_valid / out_stall quat_w .. quat_z, invalid
//
// One matrix is taken every cycle while in_stall is low. The pipeline holds, in
// order, one front stage, one square root stage per root bit (TW, the square
// root width, is 16 at the default), a divider set-up stage with the overflow check,
// one divider stage per quotient bit and one output stage.
// Reset clears only the valid bits. When a result is held by out_stall the
// whole pipeline freezes, so in_stall rises in the same cycle.
module rotation_matrix_to_quaternion_unit #(
	parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rmq_pkg::DATA_W-1:0] m00,
	input  logic signed [rmq_pkg::DATA_W-1:0] m01,
	input  logic signed [rmq_pkg::DATA_W-1:0] m02,
	input  logic signed [rmq_pkg::DATA_W-1:0] m10,
	input  logic signed [rmq_pkg::DATA_W-1:0] m11,
	input  logic signed [rmq_pkg::DATA_W-1:0] m12,
	input  logic signed [rmq_pkg::DATA_W-1:0] m20,
	input  logic signed [rmq_pkg::DATA_W-1:0] m21,
	input  logic signed [rmq_pkg::DATA_W-1:0] m22,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rmq_pkg::DATA_W-1:0] quat_w,
	output logic signed [rmq_pkg::DATA_W-1:0] quat_x,
	output logic signed [rmq_pkg::DATA_W-1:0] quat_y,
	output logic signed [rmq_pkg::DATA_W-1:0] quat_z,
	output logic                              invalid
);

	localparam int unsigned DW  = rmq_pkg::DATA_W;
	localparam int unsigned QW  = rmq_pkg::QUOT_W;
	localparam int unsigned SW  = DW + 2;           // trace width
	localparam int unsigned RMX = (FRAC_BITS > DW) ? FRAC_BITS : DW;
	localparam int unsigned RSW = RMX + 3;          // signed radicand width
	localparam int unsigned RW  = RSW - 1 + FRAC_BITS; // shifted radicand width
	localparam int unsigned TW  = (RW + 1) / 2;     // square root width
	localparam int unsigned VW  = TW + 1;           // divisor 2t width
	localparam int unsigned MW  = DW + 1;           // numerator magnitude width
	// Dividend width: holds the shifted numerator and the divisor at its top bit.
	localparam int unsigned NW  = (VW + QW > MW + FRAC_BITS + 1) ? VW + QW
		: MW + FRAC_BITS + 1;

	typedef struct packed {
		rmq_pkg::sel_t             sel;
		logic                      bad;
		logic [2:0]                neg;
		logic [2:0]                nz;
		logic [2:0][MW-1:0]        mag;
		logic [RW-1:0]             rem;
		logic [TW-1:0]             root;
	} sq_t;

	typedef struct packed {
		rmq_pkg::sel_t             sel;
		logic                      bad;
		logic [2:0]                neg;
		logic [2:0]                nz;
		logic [2:0]                ovf;
		logic [TW-1:0]             half;
		logic [VW-1:0]             dv;
		logic [2:0][NW-1:0]        rem;
		logic [2:0][QW-1:0]        quo;
	} dv_t;

	logic adv;
	logic in_acc;

	// Whole pipeline moves unless a finished transaction is being held.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// Front stage: trace, branch select, radicand and numerators.
	logic signed [SW-1:0]  trace;
	logic signed [RSW-1:0] rad;
	logic signed [MW-1:0]  num [3];
	logic signed [MW-1:0]  d_21_12, d_02_20, d_10_01, s_01_10, s_02_20, s_12_21;
	rmq_pkg::sel_t         sel_c;
	sq_t                   front_c;

	always_comb begin
		trace   = SW'(m00) + SW'(m11) + SW'(m22);
		d_21_12 = MW'(m21) - MW'(m12);
		d_02_20 = MW'(m02) - MW'(m20);
		d_10_01 = MW'(m10) - MW'(m01);
		s_01_10 = MW'(m01) + MW'(m10);
		s_02_20 = MW'(m02) + MW'(m20);
		s_12_21 = MW'(m12) + MW'(m21);
		if (trace > 0) begin
			sel_c  = rmq_pkg::SEL_W;
			rad    = RSW'(trace) + (RSW'(1) << FRAC_BITS);
			num[0] = d_21_12;
			num[1] = d_02_20;
			num[2] = d_10_01;
		end else if (m00 > m11 && m00 > m22) begin
			sel_c  = rmq_pkg::SEL_X;
			rad    = (RSW'(1) << FRAC_BITS) + RSW'(m00) - RSW'(m11) - RSW'(m22);
			num[0] = d_21_12;
			num[1] = s_01_10;
			num[2] = s_02_20;
		end else if (m11 > m22) begin
			sel_c  = rmq_pkg::SEL_Y;
			rad    = (RSW'(1) << FRAC_BITS) + RSW'(m11) - RSW'(m00) - RSW'(m22);
			num[0] = d_02_20;
			num[1] = s_01_10;
			num[2] = s_12_21;
		end else begin
			sel_c  = rmq_pkg::SEL_Z;
			rad    = (RSW'(1) << FRAC_BITS) + RSW'(m22) - RSW'(m00) - RSW'(m11);
			num[0] = d_10_01;
			num[1] = s_02_20;
			num[2] = s_12_21;
		end
		front_c.sel  = sel_c;
		front_c.bad  = (rad <= 0);
		front_c.root = '0;
		if (rad <= 0) begin
			front_c.rem = '0;
		end else begin
			front_c.rem = RW'(rad[RSW-2:0]) << FRAC_BITS;
		end
		for (int k = 0; k < 3; k++) begin
			front_c.neg[k] = num[k][MW-1];
			front_c.nz[k]  = (num[k] != '0);
			front_c.mag[k] = num[k][MW-1] ? MW'(-num[k]) : MW'(num[k]);
		end
	end

	// Square root pipeline: one result bit per stage, largest bit first.
	sq_t             sq_s [TW+1];
	logic [TW:0]     sq_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq_vld_s[0] <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= front_c;
		end
	end

	for (genvar k = 0; k < TW; k++) begin : g_sqrt
		localparam int unsigned BI = TW - 1 - k;
		logic [RW-1:0] trial;
		sq_t           nxt;

		always_comb begin
			nxt   = sq_s[k];
			trial = (RW'(sq_s[k].root) << (BI + 1)) | (RW'(1) << (2 * BI));
			if (sq_s[k].rem >= trial) begin
				nxt.rem       = sq_s[k].rem - trial;
				nxt.root[BI]  = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Divider set-up: dividend, divisor 2t and the quotient overflow check.
	dv_t         dv_s [QW+1];
	logic [QW:0] dv_vld_s;
	dv_t         dv_first_c;

	always_comb begin
		dv_first_c.sel  = sq_s[TW].sel;
		dv_first_c.bad  = sq_s[TW].bad;
		dv_first_c.neg  = sq_s[TW].neg;
		dv_first_c.nz   = sq_s[TW].nz;
		dv_first_c.half = TW'((VW'(sq_s[TW].root) + VW'(1)) >> 1);
		dv_first_c.dv   = {sq_s[TW].root, 1'b0};
		dv_first_c.quo  = '0;
		for (int k = 0; k < 3; k++) begin
			dv_first_c.rem[k] = (NW'(sq_s[TW].mag[k]) << FRAC_BITS) + NW'(sq_s[TW].root);
			dv_first_c.ovf[k] = (dv_first_c.rem[k] >= (NW'(dv_first_c.dv) << QW));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= sq_vld_s[TW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv_first_c;
		end
	end

	// Restoring division, three lanes side by side, one quotient bit a stage.
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int unsigned BI = QW - 1 - j;
		logic [NW-1:0] sub;
		dv_t           nxt;

		always_comb begin
			nxt = dv_s[j];
			sub = NW'(dv_s[j].dv) << BI;
			for (int k = 0; k < 3; k++) begin
				if (dv_s[j].rem[k] >= sub) begin
					nxt.rem[k]     = dv_s[j].rem[k] - sub;
					nxt.quo[k][BI] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+1] <= nxt;
			end
		end
	end

	// Output stage: sign, saturation and placement of the components.
	logic [DW-1:0] lane_c [3];
	logic [DW-1:0] half_c;
	logic [QW-1:0] qm;
	logic [DW-1:0] w_c, x_c, y_c, z_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qm = dv_s[QW].ovf[k] ? '1 : dv_s[QW].quo[k];
			if (!dv_s[QW].nz[k]) begin
				lane_c[k] = '0;
			end else if (dv_s[QW].neg[k]) begin
				lane_c[k] = (qm > QW'(32768)) ? DW'(16'h8000) : DW'(-qm);
			end else begin
				lane_c[k] = (qm > QW'(32767)) ? DW'(16'h7FFF) : DW'(qm);
			end
		end
		half_c = (32'(dv_s[QW].half) > 32'd32767) ? DW'(16'h7FFF) : DW'(dv_s[QW].half);
		case (dv_s[QW].sel)
			rmq_pkg::SEL_W: begin
				w_c = half_c;    x_c = lane_c[0]; y_c = lane_c[1]; z_c = lane_c[2];
			end
			rmq_pkg::SEL_X: begin
				w_c = lane_c[0]; x_c = half_c;    y_c = lane_c[1]; z_c = lane_c[2];
			end
			rmq_pkg::SEL_Y: begin
				w_c = lane_c[0]; x_c = lane_c[1]; y_c = half_c;    z_c = lane_c[2];
			end
			default: begin
				w_c = lane_c[0]; x_c = lane_c[1]; y_c = lane_c[2]; z_c = half_c;
			end
		endcase
	end

	logic          out_vld_q;
	logic [DW-1:0] w_q, x_q, y_q, z_q;
	logic          bad_q;
	rmq_pkg::sel_t sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_q   <= w_c;
			x_q   <= x_c;
			y_q   <= y_c;
			z_q   <= z_c;
			bad_q <= dv_s[QW].bad;
			sel_q <= dv_s[QW].sel;
		end
	end

	assign out_valid = out_vld_q;
	assign quat_w    = w_q;
	assign quat_x    = x_q;
	assign quat_y    = y_q;
	assign quat_z    = z_q;
	assign invalid   = bad_q;

`ifndef SYNTHESIS
	// An accepted transaction always lands in the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> sq_vld_s[0])
		else $error("accepted transaction missing from first stage");

	// A positive radicand always leaves a non-zero root.
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld_s[TW] && !sq_s[TW].bad |-> sq_s[TW].root != '0)
		else $error("zero root for a positive radicand");

	// The trace branch never flags an invalid radicand.
	a_trace_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> sel_q != rmq_pkg::SEL_W)
		else $error("invalid flag raised in the trace branch");

	// An invalid transaction in the x branch gives a zero half-root component.
	a_bad_half_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid && sel_q == rmq_pkg::SEL_X |-> quat_x == '0)
		else $error("non-zero half component for an invalid radicand");
`endif

endmodule
